@@ design/bpsnr_pkg.sv @@
// Shared types, constants and the elaboration-time log2 helper for the block PSNR compare core.
`timescale 1ns / 1ps
`default_nettype none

package bpsnr_pkg;

  localparam int unsigned BLOCK_ROWS    = 8;
  localparam int unsigned ROWS_W        = 4;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned PIXELS        = 8;
  localparam int unsigned ROW_W         = PIX_W * PIXELS;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned SUM_W         = 23;
  localparam int unsigned THR_W         = 15;
  localparam int unsigned PSNR_W        = 15;
  localparam int unsigned FRAC_BITS     = 28;
  localparam int unsigned EXP_W         = 5;
  localparam int unsigned LOG_W         = EXP_W + FRAC_BITS;
  localparam int unsigned MUL_W         = 32;
  localparam int unsigned PROD_W        = 2 * MUL_W;
  localparam int unsigned DL_LO_W       = 17;
  localparam int unsigned IT_W          = 5;
  localparam int unsigned OUT_DATA_W    = 24;

  localparam logic [ROWS_W-1:0] CHROMA_FULL_ROWS = 4'd8;
  localparam logic [PSNR_W-1:0] PSNR_MAX_Q8      = 15'd25600;
  localparam logic [THR_W-1:0]  LUMA_THR_RESET   = 15'd8192;
  localparam logic [THR_W-1:0]  CHROMA_THR_RESET = 15'd9216;
  localparam logic [MUL_W-1:0]  DB_PER_LOG2_Q20  = 32'd808071242;

  localparam logic [SUM_W-1:0] PEAK_N_LUMA = 23'd65025;
  localparam logic [SUM_W-1:0] PEAK_N_C64  = 23'd4161600;
  localparam logic [SUM_W-1:0] PEAK_N_C32  = 23'd2080800;

  localparam logic CFG_LUMA_THR   = 1'b0;
  localparam logic CFG_CHROMA_THR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_CHECK,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_STEP,
    ST_DIFF,
    ST_PROD_LO,
    ST_PROD_HI,
    ST_ACC,
    ST_ROUND,
    ST_FINISH
  } state_e;

  // Evaluated only for constants: log2 in Q28 by repeated truncated squaring.
  function automatic logic [LOG_W-1:0] log2_q28(input logic [MUL_W-1:0] x);
    logic [EXP_W-1:0]     e;
    logic [PROD_W-1:0]    m;
    logic [FRAC_BITS-1:0] frac;
    e = '0;
    for (int i = 1; i < MUL_W; i++) begin
      if ((x >> i) != '0) begin
        e = EXP_W'(i);
      end
    end
    m = (PROD_W'(x) << (EXP_W'(MUL_W - 1) - e)) & PROD_W'({MUL_W{1'b1}});
    frac = '0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      m = (m * m) >> (MUL_W - 1);
      frac = {frac[FRAC_BITS-2:0], 1'b0};
      if (m >= (PROD_W'(1) << MUL_W)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {e, frac};
  endfunction

  localparam logic [LOG_W-1:0] LOG_N_LUMA = log2_q28(MUL_W'(PEAK_N_LUMA));
  localparam logic [LOG_W-1:0] LOG_N_C64  = log2_q28(MUL_W'(PEAK_N_C64));
  localparam logic [LOG_W-1:0] LOG_N_C32  = log2_q28(MUL_W'(PEAK_N_C32));

endpackage

`default_nettype wire

@@ design/bpsnr_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module bpsnr_mul (
  input  wire logic                            clk_i,
  input  wire logic [bpsnr_pkg::MUL_W-1:0]     op_a_i,
  input  wire logic [bpsnr_pkg::MUL_W-1:0]     op_b_i,
  output logic      [bpsnr_pkg::PROD_W-1:0]    prod_o
);

  logic [bpsnr_pkg::PROD_W-1:0] prod_d;
  logic [bpsnr_pkg::PROD_W-1:0] prod_q;

  assign prod_d = bpsnr_pkg::PROD_W'(op_a_i) * bpsnr_pkg::PROD_W'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ design/block_psnr_compare_core.sv @@
// Top level of the block PSNR compare core: row accumulation, log2 sequencer and result register.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata = row_a, row_b; tuser = is_chroma; tlast = last_row
//  m_axis   out        tdata = psnr_q8, similar, rows_used
//  cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (threshold registers)
//
// A row that does not end a block is followed by the next accept once its pixels are summed. A row
// that ends a block with a nonzero error below the peak also runs the normalization shift, 28 squarings
// for the log2 and a two-part scale multiply; all but the shift use the one 32x32 multiplier.
// Reset returns the thresholds to 32 dB and 36 dB and clears the accumulator.
// A result waiting on m_axis does not block the next row; only the next result does.
`timescale 1ns / 1ps
`default_nettype none

module block_psnr_compare_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // row_a [63:0], row_b [127:64]
  input  wire logic [2*bpsnr_pkg::ROW_W-1:0]        s_axis_tdata,
  // is_chroma [0]
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // psnr_q8 [14:0], similar [15], rows_used [19:16], zero [23:20]
  output logic      [bpsnr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic [bpsnr_pkg::THR_W-1:0]          cfg_data_i
);

  localparam int unsigned RW = bpsnr_pkg::ROW_W;
  localparam int unsigned PW = bpsnr_pkg::PIX_W;

  bpsnr_pkg::state_e state_q, state_d;

  logic [RW-1:0]                       a_q, a_d, b_q, b_d;
  logic                                chroma_q, chroma_d, last_q, last_d;
  logic [bpsnr_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic [bpsnr_pkg::SUM_W-1:0]         sum_q, sum_d;
  logic [bpsnr_pkg::ROWS_W-1:0]        cnt_q, cnt_d, rows_q, rows_d;
  logic [bpsnr_pkg::MUL_W-1:0]         m_q, m_d;
  logic [bpsnr_pkg::EXP_W-1:0]         e_q, e_d;
  logic [bpsnr_pkg::FRAC_BITS-1:0]     frac_q, frac_d;
  logic [bpsnr_pkg::IT_W-1:0]          it_q, it_d;
  logic [bpsnr_pkg::LOG_W-1:0]         dl_q, dl_d;
  logic [bpsnr_pkg::PROD_W-1:0]        acc_q, acc_d;
  logic [bpsnr_pkg::PSNR_W-1:0]        psnr_q, psnr_d;
  logic [bpsnr_pkg::THR_W-1:0]         luma_thr_q, luma_thr_d, chroma_thr_q, chroma_thr_d;
  logic                                out_vld_q, out_vld_d;
  logic [bpsnr_pkg::PSNR_W-1:0]        out_psnr_q, out_psnr_d;
  logic                                out_sim_q, out_sim_d;
  logic [bpsnr_pkg::ROWS_W-1:0]        out_rows_q, out_rows_d;

  logic [bpsnr_pkg::MUL_W-1:0]         op_a, op_b;
  logic [bpsnr_pkg::PROD_W-1:0]        prod;
  logic [PW-1:0]                       pix_a, pix_b, pix_d;
  logic [bpsnr_pkg::ROWS_W-1:0]        rows_next;
  logic [bpsnr_pkg::SUM_W-1:0]         err_m, peak_n;
  logic [bpsnr_pkg::LOG_W-1:0]         log_n;
  logic [bpsnr_pkg::MUL_W:0]           sq_v;
  logic [16:0]                         rnd;
  logic [15:0]                         q_round;
  logic [bpsnr_pkg::THR_W-1:0]         thr_sel;
  logic                                in_fire, out_fire;

  bpsnr_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == bpsnr_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_vld_q && m_axis_tready;

  assign pix_a     = a_q[idx_q*PW +: PW];
  assign pix_b     = b_q[idx_q*PW +: PW];
  assign pix_d     = (pix_a >= pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
  assign rows_next = cnt_q + 1'b1;
  assign sq_v      = prod[2*bpsnr_pkg::MUL_W-1:bpsnr_pkg::MUL_W-1];
  assign rnd       = 17'(acc_q[63:47]) + 17'd1;
  assign q_round   = rnd[16:1];
  assign thr_sel   = chroma_q ? chroma_thr_q : luma_thr_q;

  always_comb begin
    if (!chroma_q) begin
      err_m  = sum_q >> 6;
      peak_n = bpsnr_pkg::PEAK_N_LUMA;
      log_n  = bpsnr_pkg::LOG_N_LUMA;
    end else if (rows_q == bpsnr_pkg::CHROMA_FULL_ROWS) begin
      err_m  = sum_q;
      peak_n = bpsnr_pkg::PEAK_N_C64;
      log_n  = bpsnr_pkg::LOG_N_C64;
    end else begin
      err_m  = sum_q;
      peak_n = bpsnr_pkg::PEAK_N_C32;
      log_n  = bpsnr_pkg::LOG_N_C32;
    end
  end

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    chroma_d     = chroma_q;
    last_d       = last_q;
    idx_d        = idx_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    rows_d       = rows_q;
    m_d          = m_q;
    e_d          = e_q;
    frac_d       = frac_q;
    it_d         = it_q;
    dl_d         = dl_q;
    acc_d        = acc_q;
    psnr_d       = psnr_q;
    luma_thr_d   = luma_thr_q;
    chroma_thr_d = chroma_thr_q;
    out_vld_d    = out_vld_q && !out_fire;
    out_psnr_d   = out_psnr_q;
    out_sim_d    = out_sim_q;
    out_rows_d   = out_rows_q;
    op_a         = '0;
    op_b         = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == bpsnr_pkg::CFG_LUMA_THR) begin
        luma_thr_d = cfg_data_i;
      end else begin
        chroma_thr_d = cfg_data_i;
      end
    end

    case (state_q)
      bpsnr_pkg::ST_IDLE: begin
        if (in_fire) begin
          a_d      = s_axis_tdata[RW-1:0];
          b_d      = s_axis_tdata[2*RW-1:RW];
          chroma_d = s_axis_tuser;
          last_d   = s_axis_tlast;
          idx_d    = '0;
          state_d  = bpsnr_pkg::ST_SQ_MUL;
        end
      end
      bpsnr_pkg::ST_SQ_MUL: begin
        op_a    = bpsnr_pkg::MUL_W'(pix_d);
        op_b    = bpsnr_pkg::MUL_W'(pix_d);
        state_d = bpsnr_pkg::ST_SQ_ADD;
      end
      bpsnr_pkg::ST_SQ_ADD: begin
        sum_d = sum_q + prod[bpsnr_pkg::SUM_W-1:0];
        idx_d = idx_q + 1'b1;
        if (idx_q == bpsnr_pkg::IDX_W'(bpsnr_pkg::PIXELS - 1)) begin
          if (last_q || (rows_next >= bpsnr_pkg::ROWS_W'(bpsnr_pkg::BLOCK_ROWS))) begin
            rows_d  = rows_next;
            state_d = bpsnr_pkg::ST_CHECK;
          end else begin
            cnt_d   = rows_next;
            state_d = bpsnr_pkg::ST_IDLE;
          end
        end else begin
          state_d = bpsnr_pkg::ST_SQ_MUL;
        end
      end
      bpsnr_pkg::ST_CHECK: begin
        sum_d = '0;
        cnt_d = '0;
        if (err_m == '0) begin
          psnr_d  = bpsnr_pkg::PSNR_MAX_Q8;
          state_d = bpsnr_pkg::ST_FINISH;
        end else if (err_m >= peak_n) begin
          psnr_d  = '0;
          state_d = bpsnr_pkg::ST_FINISH;
        end else begin
          m_d     = bpsnr_pkg::MUL_W'(err_m);
          e_d     = bpsnr_pkg::EXP_W'(bpsnr_pkg::MUL_W - 1);
          state_d = bpsnr_pkg::ST_NORM;
        end
      end
      bpsnr_pkg::ST_NORM: begin
        if (m_q[bpsnr_pkg::MUL_W-1]) begin
          it_d    = '0;
          frac_d  = '0;
          state_d = bpsnr_pkg::ST_LOG_MUL;
        end else begin
          m_d = m_q << 1;
          e_d = e_q - 1'b1;
        end
      end
      bpsnr_pkg::ST_LOG_MUL: begin
        op_a    = m_q;
        op_b    = m_q;
        state_d = bpsnr_pkg::ST_LOG_STEP;
      end
      bpsnr_pkg::ST_LOG_STEP: begin
        frac_d = {frac_q[bpsnr_pkg::FRAC_BITS-2:0], sq_v[bpsnr_pkg::MUL_W]};
        m_d    = sq_v[bpsnr_pkg::MUL_W] ? sq_v[bpsnr_pkg::MUL_W:1]
                                        : sq_v[bpsnr_pkg::MUL_W-1:0];
        it_d   = it_q + 1'b1;
        if (it_q == bpsnr_pkg::IT_W'(bpsnr_pkg::FRAC_BITS - 1)) begin
          state_d = bpsnr_pkg::ST_DIFF;
        end else begin
          state_d = bpsnr_pkg::ST_LOG_MUL;
        end
      end
      bpsnr_pkg::ST_DIFF: begin
        dl_d    = log_n - {e_q, frac_q};
        state_d = bpsnr_pkg::ST_PROD_LO;
      end
      bpsnr_pkg::ST_PROD_LO: begin
        op_a    = bpsnr_pkg::MUL_W'(dl_q[bpsnr_pkg::DL_LO_W-1:0]);
        op_b    = bpsnr_pkg::DB_PER_LOG2_Q20;
        state_d = bpsnr_pkg::ST_PROD_HI;
      end
      bpsnr_pkg::ST_PROD_HI: begin
        acc_d   = prod;
        op_a    = bpsnr_pkg::MUL_W'(dl_q[bpsnr_pkg::LOG_W-1:bpsnr_pkg::DL_LO_W]);
        op_b    = bpsnr_pkg::DB_PER_LOG2_Q20;
        state_d = bpsnr_pkg::ST_ACC;
      end
      bpsnr_pkg::ST_ACC: begin
        acc_d   = acc_q + (prod << bpsnr_pkg::DL_LO_W);
        state_d = bpsnr_pkg::ST_ROUND;
      end
      bpsnr_pkg::ST_ROUND: begin
        if (q_round > 16'(bpsnr_pkg::PSNR_MAX_Q8)) begin
          psnr_d = bpsnr_pkg::PSNR_MAX_Q8;
        end else begin
          psnr_d = q_round[bpsnr_pkg::PSNR_W-1:0];
        end
        state_d = bpsnr_pkg::ST_FINISH;
      end
      bpsnr_pkg::ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_psnr_d = psnr_q;
          out_sim_d  = (psnr_q > thr_sel);
          out_rows_d = rows_q;
          state_d    = bpsnr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpsnr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpsnr_pkg::ST_IDLE;
      sum_q        <= '0;
      cnt_q        <= '0;
      out_vld_q    <= 1'b0;
      luma_thr_q   <= bpsnr_pkg::LUMA_THR_RESET;
      chroma_thr_q <= bpsnr_pkg::CHROMA_THR_RESET;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      out_vld_q    <= out_vld_d;
      luma_thr_q   <= luma_thr_d;
      chroma_thr_q <= chroma_thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    chroma_q   <= chroma_d;
    last_q     <= last_d;
    idx_q      <= idx_d;
    rows_q     <= rows_d;
    m_q        <= m_d;
    e_q        <= e_d;
    frac_q     <= frac_d;
    it_q       <= it_d;
    dl_q       <= dl_d;
    acc_q      <= acc_d;
    psnr_q     <= psnr_d;
    out_psnr_q <= out_psnr_d;
    out_sim_q  <= out_sim_d;
    out_rows_q <= out_rows_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_rows_q, out_sim_q, out_psnr_q};

`ifndef SYNTH
  // The accumulator and row count restart once a block has ended.
  a_clear_after_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsnr_pkg::ST_CHECK) |=> (sum_q == '0 && cnt_q == '0))
    else $error("accumulator not cleared at block end");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < bpsnr_pkg::ROWS_W'(bpsnr_pkg::BLOCK_ROWS))
    else $error("row counter reached block size");

  // The mantissa stays normalized through every squaring step.
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsnr_pkg::ST_LOG_MUL) |-> m_q[bpsnr_pkg::MUL_W-1])
    else $error("log2 mantissa lost normalization");

  a_psnr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_psnr_q <= bpsnr_pkg::PSNR_MAX_Q8 && out_rows_q != '0))
    else $error("result word out of range");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpsnr_pkg::ST_FINISH && out_vld_q && !m_axis_tready)
      |=> (state_q == bpsnr_pkg::ST_FINISH))
    else $error("result dropped while output register was full");
`endif

endmodule

`default_nettype wire
